@@ src/peus_pkg.sv @@
package peus_pkg;

    localparam int ADDR_BITS = 64;
    localparam int ADDR_W = 64;
    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_W'(1) << ADDR_BITS) - ADDR_W'(1);

    localparam logic [31:0] OP_MFLR_R0 = 32'h7c0802a6;
    localparam logic [31:0] OP_STW_R0_R1 = 32'h90010000;
    localparam logic [31:0] OP_STWU_R1 = 32'h94210000;
    localparam logic [31:0] OP_MTLR_R0 = 32'h7c0803a6;
    localparam logic [31:0] OP_LWZ_R0_R1 = 32'h80010000;
    localparam logic [31:0] OP_ADDI_R1_R1 = 32'h38210000;
    localparam logic [31:0] OP_MR_R1_MASK = 32'hffc003ff;
    localparam logic [31:0] OP_MR_R1 = 32'h7d400378;
    localparam logic [31:0] OP_BLR = 32'h4e800020;
    localparam logic [31:0] HI_MASK = 32'hffff0000;

    localparam logic [1:0] RA_REG_NONE = 2'd0;
    localparam logic [1:0] RA_REG_LR = 2'd1;
    localparam logic [1:0] RA_REG_R0 = 2'd2;

    localparam logic REC_INTERVAL = 1'b0;
    localparam logic REC_END = 1'b1;

    localparam int MAX_RECS = 3;

    typedef struct packed {
        logic       in_frame;
        logic [1:0] ra_reg;
        logic       frame_saved;
    } ra_state_t;

    typedef struct packed {
        logic signed [16:0] frame_bytes;
        logic signed [15:0] saved_ra_offset;
        ra_state_t          cur;
        ra_state_t          canon;
        logic               canon_taken;
    } unwind_state_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] addr;
        ra_state_t         ra;
    } record_t;

    localparam ra_state_t RA_STATE_RESET = '{in_frame: 1'b0, ra_reg: RA_REG_LR,
                                             frame_saved: 1'b0};

    localparam unwind_state_t STATE_RESET = '{frame_bytes: 17'sd0, saved_ra_offset: 16'sd0,
                                              cur: RA_STATE_RESET, canon: RA_STATE_RESET,
                                              canon_taken: 1'b0};

endpackage

@@ src/peus_decode.sv @@
module peus_decode (
    input  logic [31:0]                       ins_word,
    input  logic [peus_pkg::ADDR_W-1:0]       ins_addr,
    input  logic                              routine_first,
    input  logic                              routine_last,
    input  peus_pkg::unwind_state_t           state,
    output peus_pkg::unwind_state_t           state_next,
    output peus_pkg::record_t [peus_pkg::MAX_RECS-1:0] recs,
    output logic [1:0]                        rec_count
);

    peus_pkg::unwind_state_t   base;
    peus_pkg::unwind_state_t   ns;
    logic signed [15:0]        disp;
    logic [31:0]               hi;
    logic signed [17:0]        fb_plus4;
    logic [peus_pkg::ADDR_W-1:0] addr_m;
    logic [peus_pkg::ADDR_W-1:0] next_addr;
    logic                      change;
    logic [1:0]                cnt;

    always_comb
    begin
        base = routine_first ? peus_pkg::STATE_RESET : state;
        ns = base;
        change = 1'b0;
        disp = signed'(ins_word[15:0]);
        hi = ins_word & peus_pkg::HI_MASK;
        fb_plus4 = 18'(base.frame_bytes) + 18'sd4;
        addr_m = ins_addr & peus_pkg::ADDR_MASK;
        next_addr = (addr_m + peus_pkg::ADDR_W'(4)) & peus_pkg::ADDR_MASK;

        if (ins_word == peus_pkg::OP_MFLR_R0)
        begin
            ns.cur.in_frame = 1'b0;
            ns.cur.ra_reg = peus_pkg::RA_REG_R0;
            change = 1'b1;
        end
        else if (hi == peus_pkg::OP_STW_R0_R1)
        begin
            ns.saved_ra_offset = disp;
            if ((fb_plus4 == 18'(disp)) && (disp > 16'sd4))
            begin
                ns.cur.in_frame = 1'b1;
                ns.cur.ra_reg = peus_pkg::RA_REG_NONE;
                ns.cur.frame_saved = 1'b1;
                change = 1'b1;
                if (!base.canon_taken)
                begin
                    ns.canon_taken = 1'b1;
                    ns.canon.in_frame = 1'b1;
                    ns.canon.ra_reg = peus_pkg::RA_REG_NONE;
                    ns.canon.frame_saved = 1'b1;
                end
            end
        end
        else if (hi == peus_pkg::OP_STWU_R1)
        begin
            ns.cur.in_frame = 1'b0;
            ns.cur.frame_saved = 1'b1;
            ns.frame_bytes = -17'(disp);
            change = 1'b1;
        end
        else if (ins_word == peus_pkg::OP_MTLR_R0)
        begin
            ns.cur.in_frame = 1'b0;
            ns.cur.ra_reg = peus_pkg::RA_REG_LR;
            change = 1'b1;
        end
        else if (((ins_word & peus_pkg::OP_MR_R1_MASK) == peus_pkg::OP_MR_R1) ||
                 ((hi == peus_pkg::OP_ADDI_R1_R1) && (17'(disp) == base.frame_bytes)))
        begin
            ns.cur.frame_saved = 1'b0;
            change = 1'b1;
        end
        else if (hi == peus_pkg::OP_LWZ_R0_R1)
        begin
            if (disp == base.saved_ra_offset)
            begin
                ns.cur.in_frame = 1'b0;
                ns.cur.ra_reg = peus_pkg::RA_REG_R0;
                change = 1'b1;
            end
        end
        else if ((ins_word == peus_pkg::OP_BLR) && !routine_last)
        begin
            if (base.cur != base.canon)
            begin
                ns.cur = base.canon;
                change = 1'b1;
            end
        end

        recs = '0;
        cnt = 2'd0;
        if (routine_first)
        begin
            recs[cnt] = '{kind: peus_pkg::REC_INTERVAL, addr: addr_m,
                          ra: peus_pkg::RA_STATE_RESET};
            cnt = cnt + 2'd1;
        end
        if (change)
        begin
            recs[cnt] = '{kind: peus_pkg::REC_INTERVAL, addr: next_addr, ra: ns.cur};
            cnt = cnt + 2'd1;
        end
        if (routine_last)
        begin
            recs[cnt] = '{kind: peus_pkg::REC_END, addr: next_addr, ra: ns.cur};
            cnt = cnt + 2'd1;
        end
    end

    assign state_next = ns;
    assign rec_count = cnt;

endmodule

@@ src/prologue_epilogue_unwind_scanner_core.sv @@
// Scans the instruction words of 32-bit PowerPC routines for prologue and
// epilogue instructions and produces unwind-interval records.
// The input channel takes one word per instruction: ins_word, ins_addr and
// the routine_first and routine_last marks, under in_valid and in_stall.
// The output channel gives one record at a time under out_valid and out_stall.
// An instruction may cause zero to three records; last_of_run marks the
// final record that one instruction causes.
// A word is registered in the decode register on acceptance, and its first
// record is then loaded into the output register when that register has room.
// Words that cause no record or one record stream at one per cycle while the
// output is not stalled; an instruction that causes several records holds the
// decode register until each of them has been loaded into the single output
// register.
// When the receiver stalls, the output register holds its record and the
// decode register holds its instruction; in_stall rises once both are full.
// Reset empties both registers and returns the tracking state to its
// initial values: return address in the link register, no frame saved.
module prologue_epilogue_unwind_scanner_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [31:0]                 ins_word,
    input  logic [peus_pkg::ADDR_W-1:0] ins_addr,
    input  logic                        routine_first,
    input  logic                        routine_last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        record_kind,
    output logic [peus_pkg::ADDR_W-1:0] rec_addr,
    output logic                        ra_in_frame,
    output logic [1:0]                  ra_reg_id,
    output logic                        frame_saved,
    output logic                        last_of_run
);

    logic                        stage_valid_reg;
    logic                        stage_valid_next;
    logic [31:0]                 word_reg;
    logic [peus_pkg::ADDR_W-1:0] addr_reg;
    logic                        first_reg;
    logic                        last_reg;
    logic [1:0]                  sel_reg;
    logic [1:0]                  sel_next;
    peus_pkg::unwind_state_t     state_reg;
    peus_pkg::unwind_state_t     state_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    peus_pkg::record_t           out_rec_reg;
    logic                        out_last_reg;

    peus_pkg::record_t [peus_pkg::MAX_RECS-1:0] recs;
    logic [1:0]                  rec_count;
    logic                        out_room;
    logic                        load_out;
    logic                        final_rec;
    logic                        retire;
    logic                        in_ready;
    logic                        accept;

    peus_decode u_decode (
        .ins_word      (word_reg),
        .ins_addr      (addr_reg),
        .routine_first (first_reg),
        .routine_last  (last_reg),
        .state         (state_reg),
        .state_next    (state_next),
        .recs          (recs),
        .rec_count     (rec_count)
    );

    always_comb
    begin
        out_room = !out_valid_reg || !out_stall;
        load_out = stage_valid_reg && (rec_count != 2'd0) && out_room;
        final_rec = (sel_reg == 2'(rec_count - 2'd1));
        retire = stage_valid_reg && ((rec_count == 2'd0) || (load_out && final_rec));
        in_ready = !stage_valid_reg || retire;
        accept = in_valid && in_ready;

        stage_valid_next = accept ? 1'b1 : (retire ? 1'b0 : stage_valid_reg);
        if (retire)
            sel_next = 2'd0;
        else if (load_out)
            sel_next = sel_reg + 2'd1;
        else
            sel_next = sel_reg;
        out_valid_next = load_out ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            sel_reg <= 2'd0;
            out_valid_reg <= 1'b0;
            state_reg <= peus_pkg::STATE_RESET;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            sel_reg <= sel_next;
            out_valid_reg <= out_valid_next;
            if (retire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= ins_word;
            addr_reg <= ins_addr;
            first_reg <= routine_first;
            last_reg <= routine_last;
        end
        if (load_out)
        begin
            out_rec_reg <= recs[sel_reg];
            out_last_reg <= final_rec;
        end
    end

    assign in_stall = !in_ready;
    assign out_valid = out_valid_reg;
    assign record_kind = out_rec_reg.kind;
    assign rec_addr = out_rec_reg.addr;
    assign ra_in_frame = out_rec_reg.ra.in_frame;
    assign ra_reg_id = out_rec_reg.ra.ra_reg;
    assign frame_saved = out_rec_reg.ra.frame_saved;
    assign last_of_run = out_last_reg;

endmodule

@@ tb/prologue_epilogue_unwind_scanner_core_test.sv @@
module prologue_epilogue_unwind_scanner_core_test;

    typedef struct {
        logic [31:0]                 word;
        logic [peus_pkg::ADDR_W-1:0] addr;
        logic                        first;
        logic                        last;
    } scan_word_t;

    typedef struct {
        peus_pkg::record_t rec;
        logic              last;
    } unwind_rec_t;

    localparam int RANDOM_WORDS = 335;
    localparam int TAIL_WORDS = 40;
    localparam int DRAIN_CYCLES = 12;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [31:0]                 ins_word = '0;
    logic [peus_pkg::ADDR_W-1:0] ins_addr = '0;
    logic                        routine_first = 1'b0;
    logic                        routine_last = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        record_kind;
    logic [peus_pkg::ADDR_W-1:0] rec_addr;
    logic                        ra_in_frame;
    logic [1:0]                  ra_reg_id;
    logic                        frame_saved;
    logic                        last_of_run;

    scan_word_t  pending_words[$];
    unwind_rec_t unwind_records[$];
    int          mismatches = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    logic        tail_phase = 1'b0;

    logic signed [16:0]  frame_len;
    logic signed [15:0]  ra_slot;
    peus_pkg::ra_state_t cur_ra;
    peus_pkg::ra_state_t canon_ra;
    logic                canon_set;

    prologue_epilogue_unwind_scanner_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .ins_word      (ins_word),
        .ins_addr      (ins_addr),
        .routine_first (routine_first),
        .routine_last  (routine_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .record_kind   (record_kind),
        .rec_addr      (rec_addr),
        .ra_in_frame   (ra_in_frame),
        .ra_reg_id     (ra_reg_id),
        .frame_saved   (frame_saved),
        .last_of_run   (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic clear_tracking();
        frame_len = '0;
        ra_slot = '0;
        cur_ra = peus_pkg::RA_STATE_RESET;
        canon_ra = peus_pkg::RA_STATE_RESET;
        canon_set = 1'b0;
    endtask

    function automatic peus_pkg::record_t make_record(logic kind,
                                                      logic [peus_pkg::ADDR_W-1:0] a);
        peus_pkg::record_t r;
        r.kind = kind;
        r.addr = a & peus_pkg::ADDR_MASK;
        r.ra = cur_ra;
        return r;
    endfunction

    task automatic scan_word(input scan_word_t sw);
        logic [peus_pkg::ADDR_W-1:0] a;
        logic [peus_pkg::ADDR_W-1:0] nxt;
        logic [31:0]                 hi;
        int                          d;
        logic                        change;
        peus_pkg::record_t           recs[$];
        unwind_rec_t                 er;
        a = sw.addr & peus_pkg::ADDR_MASK;
        nxt = (a + peus_pkg::ADDR_W'(4)) & peus_pkg::ADDR_MASK;
        hi = sw.word & peus_pkg::HI_MASK;
        d = int'($signed(sw.word[15:0]));
        change = 1'b0;
        if (sw.first)
        begin
            clear_tracking();
            recs.push_back(make_record(peus_pkg::REC_INTERVAL, a));
        end
        if (sw.word == peus_pkg::OP_MFLR_R0)
        begin
            cur_ra.in_frame = 1'b0;
            cur_ra.ra_reg = peus_pkg::RA_REG_R0;
            change = 1'b1;
        end
        else if (hi == peus_pkg::OP_STW_R0_R1)
        begin
            ra_slot = 16'(d);
            if (int'(frame_len) + 4 == d && d > 4)
            begin
                cur_ra = '{in_frame: 1'b1, ra_reg: peus_pkg::RA_REG_NONE,
                           frame_saved: 1'b1};
                change = 1'b1;
                if (!canon_set)
                begin
                    canon_set = 1'b1;
                    canon_ra = cur_ra;
                end
            end
        end
        else if (hi == peus_pkg::OP_STWU_R1)
        begin
            cur_ra.in_frame = 1'b0;
            cur_ra.frame_saved = 1'b1;
            frame_len = 17'(-d);
            change = 1'b1;
        end
        else if (sw.word == peus_pkg::OP_MTLR_R0)
        begin
            cur_ra.in_frame = 1'b0;
            cur_ra.ra_reg = peus_pkg::RA_REG_LR;
            change = 1'b1;
        end
        else if ((sw.word & peus_pkg::OP_MR_R1_MASK) == peus_pkg::OP_MR_R1 ||
                 (hi == peus_pkg::OP_ADDI_R1_R1 && d == int'(frame_len)))
        begin
            cur_ra.frame_saved = 1'b0;
            change = 1'b1;
        end
        else if (hi == peus_pkg::OP_LWZ_R0_R1)
        begin
            if (d == int'(ra_slot))
            begin
                cur_ra.in_frame = 1'b0;
                cur_ra.ra_reg = peus_pkg::RA_REG_R0;
                change = 1'b1;
            end
        end
        else if (sw.word == peus_pkg::OP_BLR && !sw.last)
        begin
            if (cur_ra != canon_ra)
            begin
                cur_ra = canon_ra;
                change = 1'b1;
            end
        end
        if (change)
            recs.push_back(make_record(peus_pkg::REC_INTERVAL, nxt));
        if (sw.last)
            recs.push_back(make_record(peus_pkg::REC_END, nxt));
        foreach (recs[i])
        begin
            er.rec = recs[i];
            er.last = (i == recs.size() - 1);
            unwind_records.push_back(er);
        end
    endtask

    function automatic logic [31:0] pick_word(int fsz);
        case ($urandom_range(0, 11))
            0: return peus_pkg::OP_MFLR_R0;
            1: return peus_pkg::OP_STWU_R1 | {16'h0, 16'(-fsz)};
            2: return peus_pkg::OP_STW_R0_R1 | {16'h0, 16'(fsz + 4)};
            3: return peus_pkg::OP_STW_R0_R1 | $urandom_range(0, 65535);
            4: return peus_pkg::OP_MTLR_R0;
            5: return peus_pkg::OP_MR_R1 | ($urandom & ~peus_pkg::OP_MR_R1_MASK);
            6: return peus_pkg::OP_ADDI_R1_R1 | {16'h0, 16'(fsz)};
            7: return peus_pkg::OP_ADDI_R1_R1 | $urandom_range(0, 65535);
            8: return peus_pkg::OP_LWZ_R0_R1 | {16'h0, 16'(fsz + 4)};
            9: return peus_pkg::OP_LWZ_R0_R1 | $urandom_range(0, 65535);
            10: return peus_pkg::OP_BLR;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_word(logic [31:0] w, logic [peus_pkg::ADDR_W-1:0] a, logic f,
                            logic l);
        scan_word_t sw;
        sw.word = w;
        sw.addr = a;
        sw.first = f;
        sw.last = l;
        pending_words.push_back(sw);
    endtask

    task automatic add_routine();
        logic [peus_pkg::ADDR_W-1:0] pc;
        logic [31:0]                 body[$];
        int                          fsz;
        logic                        f;
        logic                        l;
        case ($urandom_range(0, 3))
            0: pc = 64'hffff_ffff_ffff_ff00 | peus_pkg::ADDR_W'($urandom_range(0, 255));
            1: pc = peus_pkg::ADDR_W'($urandom_range(0, 4095));
            default: pc = {$urandom, $urandom};
        endcase
        if ($urandom_range(0, 4) == 0)
            fsz = $urandom_range(1, 32763);
        else
            fsz = $urandom_range(1, 32) * 8;
        if ($urandom_range(0, 9) < 6)
        begin
            body.push_back(peus_pkg::OP_MFLR_R0);
            body.push_back(peus_pkg::OP_STWU_R1 | {16'h0, 16'(-fsz)});
            body.push_back(peus_pkg::OP_STW_R0_R1 | {16'h0, 16'(fsz + 4)});
            repeat ($urandom_range(0, 4))
                body.push_back(pick_word(fsz));
            body.push_back(peus_pkg::OP_LWZ_R0_R1 | {16'h0, 16'(fsz + 4)});
            body.push_back(peus_pkg::OP_MTLR_R0);
            if ($urandom_range(0, 1) == 0)
                body.push_back(peus_pkg::OP_ADDI_R1_R1 | {16'h0, 16'(fsz)});
            else
                body.push_back(peus_pkg::OP_MR_R1 | ($urandom & ~peus_pkg::OP_MR_R1_MASK));
            body.push_back(peus_pkg::OP_BLR);
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                body.push_back(pick_word(fsz));
        end
        foreach (body[i])
        begin
            f = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 39) == 0);
            l = (i == body.size() - 1) ? ($urandom_range(0, 19) != 0)
                                       : ($urandom_range(0, 39) == 0);
            add_word(body[i], pc, f, l);
            if ($urandom_range(0, 29) == 0)
                pc = {$urandom, $urandom};
            else
                pc = pc + peus_pkg::ADDR_W'(4);
        end
    endtask

    // Driver: a word stays on the bus until it is taken.
    always @(posedge clk)
    begin
        scan_word_t sw;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                sw.word = ins_word;
                sw.addr = ins_addr;
                sw.first = routine_first;
                sw.last = routine_last;
                scan_word(sw);
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap <= in_gap - 1;
                end
                else if (pending_words.size() > 0)
                begin
                    sw = pending_words.pop_front();
                    ins_word <= sw.word;
                    ins_addr <= sw.addr;
                    routine_first <= sw.first;
                    routine_last <= sw.last;
                    in_valid <= 1'b1;
                    if (!tail_phase && $urandom_range(0, 5) == 0)
                        in_gap <= $urandom_range(1, 9);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            tail_phase <= (pending_words.size() < TAIL_WORDS);
        end
    end

    always @(posedge clk)
    begin
        unwind_rec_t er;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (unwind_records.size() == 0)
                begin
                    $error("record at %0h arrived with none outstanding", rec_addr);
                    mismatches++;
                end
                else
                begin
                    er = unwind_records.pop_front();
                    if (record_kind !== er.rec.kind)
                    begin
                        $error("record_kind expected %0h actual %0h", er.rec.kind, record_kind);
                        mismatches++;
                    end
                    if (rec_addr !== er.rec.addr)
                    begin
                        $error("rec_addr expected %0h actual %0h", er.rec.addr, rec_addr);
                        mismatches++;
                    end
                    if (ra_in_frame !== er.rec.ra.in_frame)
                    begin
                        $error("ra_in_frame expected %0h actual %0h",
                               er.rec.ra.in_frame, ra_in_frame);
                        mismatches++;
                    end
                    if (ra_reg_id !== er.rec.ra.ra_reg)
                    begin
                        $error("ra_reg_id expected %0h actual %0h",
                               er.rec.ra.ra_reg, ra_reg_id);
                        mismatches++;
                    end
                    if (frame_saved !== er.rec.ra.frame_saved)
                    begin
                        $error("frame_saved expected %0h actual %0h",
                               er.rec.ra.frame_saved, frame_saved);
                        mismatches++;
                    end
                    if (last_of_run !== er.last)
                    begin
                        $error("last_of_run expected %0h actual %0h", er.last, last_of_run);
                        mismatches++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap <= out_gap - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!tail_phase && $urandom_range(0, 6) == 0)
                    out_gap <= $urandom_range(1, 9);
            end
        end
    end

    initial
    begin
        logic [peus_pkg::ADDR_W-1:0] pc;
        clear_tracking();

        add_word(peus_pkg::OP_MFLR_R0, 64'h0, 1'b1, 1'b1);
        add_word(32'h0000_0000, 64'hffff_ffff_ffff_fffc, 1'b1, 1'b0);

        pc = 64'hffff_ffff_ffff_fff0;
        add_word(peus_pkg::OP_MFLR_R0, pc, 1'b1, 1'b0);
        add_word(peus_pkg::OP_STWU_R1 | 32'h0000_ffe0, pc + 4, 1'b0, 1'b0);
        add_word(peus_pkg::OP_STW_R0_R1 | 32'h0000_0024, pc + 8, 1'b0, 1'b0);
        add_word(peus_pkg::OP_LWZ_R0_R1 | 32'h0000_0024, pc + 12, 1'b0, 1'b0);
        add_word(peus_pkg::OP_BLR, pc + 16, 1'b0, 1'b0);
        add_word(peus_pkg::OP_MTLR_R0, pc + 20, 1'b0, 1'b0);
        add_word(peus_pkg::OP_ADDI_R1_R1 | 32'h0000_0020, pc + 24, 1'b0, 1'b0);
        add_word(peus_pkg::OP_BLR, pc + 28, 1'b0, 1'b1);

        pc = 64'h1000;
        add_word(32'hffff_ffff, pc, 1'b1, 1'b0);
        add_word(peus_pkg::OP_STW_R0_R1 | 32'h0000_0004, pc + 4, 1'b0, 1'b0);
        add_word(peus_pkg::OP_LWZ_R0_R1 | 32'h0000_0004, pc + 8, 1'b0, 1'b0);
        add_word(peus_pkg::OP_STWU_R1 | 32'h0000_8000, pc + 12, 1'b0, 1'b0);
        add_word(peus_pkg::OP_STW_R0_R1 | 32'h0000_7fff, pc + 16, 1'b0, 1'b0);
        add_word(peus_pkg::OP_ADDI_R1_R1 | 32'h0000_8000, pc + 20, 1'b0, 1'b0);
        add_word(peus_pkg::OP_MR_R1 | ~peus_pkg::OP_MR_R1_MASK, pc + 24, 1'b0, 1'b0);
        add_word(peus_pkg::OP_BLR, pc + 28, 1'b0, 1'b0);
        add_word(peus_pkg::OP_BLR, pc + 32, 1'b0, 1'b0);
        add_word(peus_pkg::OP_STWU_R1 | 32'h0000_0008, pc + 36, 1'b0, 1'b0);
        add_word(peus_pkg::OP_STW_R0_R1 | 32'h0000_fffc, pc + 40, 1'b0, 1'b0);
        add_word(peus_pkg::OP_ADDI_R1_R1 | 32'h0000_fff8, pc + 44, 1'b0, 1'b0);
        add_word(peus_pkg::OP_MTLR_R0, pc + 48, 1'b0, 1'b1);
        add_word(peus_pkg::OP_MFLR_R0, 64'h2000, 1'b0, 1'b0);
        add_word(peus_pkg::OP_LWZ_R0_R1 | 32'h0000_fffc, 64'h2004, 1'b0, 1'b0);

        while (pending_words.size() < 25 + RANDOM_WORDS)
            add_routine();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid)
            @(posedge clk);
        while (unwind_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && unwind_records.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
